>>> rtl/sqvt_pkg.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex transform package
// Shared types and constants, and the sine table used by the front.
// ----------------------------------------------------------------------------
package sqvt_pkg;

    // one turn has SINE_DEPTH phase steps; power of two from 256 to 4096
    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W      = $clog2(SINE_DEPTH);

    localparam int DEG_TURN   = 46080;
    localparam int DEG_HALF   = 23040;

    // angle to phase index: n = (rot + 46080) * D + 23040, k = (n / 46080) mod D
    localparam int NUM_W      = 17 + IDX_W + 1;
    localparam int RECIP_SH   = NUM_W + 15;
    localparam longint unsigned RECIP_M = (64'd1 << RECIP_SH) / DEG_TURN;
    localparam int RECIP_W    = NUM_W;
    localparam int QUO_W      = IDX_W + 1;

    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int ODEPTH     = 8;
    localparam int OPTR_W     = $clog2(ODEPTH);
    localparam int OCNT_W     = $clog2(ODEPTH + 1);

    localparam logic [7:0] REG_CAMERA_X = 8'd0;
    localparam logic [7:0] REG_CAMERA_Y = 8'd1;
    localparam logic [7:0] REG_X_SCALE  = 8'd2;
    localparam logic [7:0] REG_Y_SCALE  = 8'd3;

    localparam logic [31:0] X_SCALE_RST = 32'd12884902;
    localparam logic [31:0] Y_SCALE_RST = 32'd21474836;

    localparam logic [1:0] KIND_RECT   = 2'd0;
    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    localparam logic LAYER_FLOOR = 1'b0;

    typedef struct packed {
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic [30:0]        width;
        logic [30:0]        height;
        logic signed [15:0] rotation_deg;
        logic [1:0]         draw_kind;
        logic               layer;
    } t_sprite;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic               depth;
        logic [1:0]         texture_slot;
        logic [1:0]         corner;
        logic               last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [31:0] camera_x;
        logic signed [31:0] camera_y;
        logic [31:0]        x_scale;
        logic [31:0]        y_scale;
    } t_cfg;

    // rotated half-size products, ready for the per-corner sums
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [47:0] cw;
        logic signed [47:0] sh;
        logic signed [47:0] ch;
        logic signed [47:0] sw;
        logic               depth;
        logic [1:0]         slot;
    } t_work;

    typedef logic signed [15:0] t_sine_rom [SINE_DEPTH];

    function automatic logic signed [15:0] f_sin_q15(input logic [31:0] phase);
        logic [1:0]  quad;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] acc;
        logic [63:0] q;
        quad = phase[31:30];
        z    = {34'd0, phase[29:0]};
        if (quad[0]) begin
            z = 64'd1073741824 - z;
        end
        z2  = (z * z) >> 30;
        acc = 64'd5026994 - ((64'd172272 * z2) >> 30);
        acc = 64'd85569306 - ((acc * z2) >> 30);
        acc = 64'd693598668 - ((acc * z2) >> 30);
        acc = 64'd1686629713 - ((acc * z2) >> 30);
        acc = (acc * z) >> 30;
        q   = (acc + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return quad[1] ? -$signed(q[15:0]) : $signed(q[15:0]);
    endfunction

    function automatic t_sine_rom f_build_rom();
        t_sine_rom   rom;
        logic [31:0] ph;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            ph     = 32'(k) << (32 - IDX_W);
            rom[k] = f_sin_q15(ph);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_rom();

endpackage

>>> rtl/sqvt_queue.sv
// ----------------------------------------------------------------------------
// Work queue
// Short FIFO of prepared sprites between the front and the back.
// ----------------------------------------------------------------------------
module sqvt_queue
    import sqvt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_data,
    input  logic  i_pop,
    output t_work o_data,
    output logic  o_empty,
    output logic  o_full
);

    t_work             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));

endmodule

>>> rtl/sqvt_front.sv
// ----------------------------------------------------------------------------
// Sprite front end
// Accepts sprites, turns the angle into sine and cosine, forms the products.
// ----------------------------------------------------------------------------
module sqvt_front
    import sqvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_sprite i_sprite,
    output logic    o_full,
    input  logic    i_q_pop,
    output logic    o_q_push,
    output t_work   o_q_data
);

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        w;
        logic [30:0]        h;
        logic               depth;
        logic [1:0]         slot;
    } t_carry;

    logic              accept;
    logic [QCNT_W-1:0] r_cnt;
    t_carry            carry_in;

    logic [6:0]        r_v;
    t_carry            r_c0, r_c1, r_c2, r_c3, r_c4, r_c5;
    logic signed [15:0] r_rot;
    logic [NUM_W-1:0]  r_n1, r_n2;
    logic [2*NUM_W-1:0] r_p2;
    logic [QUO_W-1:0]  r_q3;
    logic              r_ge3;
    logic [IDX_W-1:0]  r_ks4, r_kc4;
    logic signed [15:0] r_s5, r_c5v;
    t_work             r_w6;

    logic signed [17:0] ru_s;
    logic [NUM_W-1:0]   n_num;
    logic [QUO_W-1:0]   q0;
    logic [NUM_W-1:0]   rem;
    logic [QUO_W-1:0]   q_fix;
    logic [IDX_W-1:0]   k_idx;

    assign accept = i_push && !o_full;
    assign o_full = (r_cnt == QCNT_W'(QDEPTH));

    // count sprites in the front stages and the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v   <= '0;
        end else begin
            r_cnt <= r_cnt + QCNT_W'(accept) - QCNT_W'(i_q_pop);
            r_v   <= {r_v[5:0], accept};
        end
    end

    always_comb begin
        carry_in.cx    = i_sprite.centre_x;
        carry_in.cy    = i_sprite.centre_y;
        carry_in.w     = i_sprite.width;
        carry_in.h     = i_sprite.height;
        carry_in.depth = (i_sprite.layer == LAYER_FLOOR);
        carry_in.slot  = (i_sprite.draw_kind == KIND_CIRCLE) ? KIND_CIRCLE :
                         (i_sprite.draw_kind == KIND_TEXT)   ? KIND_TEXT : KIND_RECT;
    end

    always_comb begin
        ru_s  = 18'(r_rot) + 18'sd46080;
        n_num = NUM_W'(ru_s[16:0]) * NUM_W'(SINE_DEPTH) + NUM_W'(DEG_HALF);
        q0    = r_p2[RECIP_SH +: QUO_W];
        rem   = r_n2 - NUM_W'(q0) * NUM_W'(DEG_TURN);
        q_fix = r_q3 + QUO_W'(r_ge3);
        k_idx = (q_fix >= QUO_W'(SINE_DEPTH)) ? IDX_W'(q_fix - QUO_W'(SINE_DEPTH))
                                             : IDX_W'(q_fix);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c0  <= carry_in;
            r_rot <= i_sprite.rotation_deg;
        end
        r_c1  <= r_c0;
        r_n1  <= n_num;
        r_c2  <= r_c1;
        r_n2  <= r_n1;
        r_p2  <= r_n1 * RECIP_W'(RECIP_M);
        r_c3  <= r_c2;
        r_q3  <= q0;
        r_ge3 <= (rem >= NUM_W'(DEG_TURN));
        r_c4  <= r_c3;
        r_ks4 <= k_idx;
        r_kc4 <= k_idx + IDX_W'(SINE_DEPTH / 4);
        r_c5  <= r_c4;
        r_s5  <= SINE_ROM[r_ks4];
        r_c5v <= SINE_ROM[r_kc4];
        r_w6.cx    <= r_c5.cx;
        r_w6.cy    <= r_c5.cy;
        r_w6.cw    <= r_c5v * $signed({1'b0, r_c5.w});
        r_w6.sh    <= r_s5 * $signed({1'b0, r_c5.h});
        r_w6.ch    <= r_c5v * $signed({1'b0, r_c5.h});
        r_w6.sw    <= r_s5 * $signed({1'b0, r_c5.w});
        r_w6.depth <= r_c5.depth;
        r_w6.slot  <= r_c5.slot;
    end

    assign o_q_push = r_v[6];
    assign o_q_data = r_w6;

endmodule

>>> rtl/sqvt_back.sv
// ----------------------------------------------------------------------------
// Vertex back end
// Expands each sprite into four corners, scales and saturates, buffers output.
// ----------------------------------------------------------------------------
module sqvt_back
    import sqvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_empty,
    input  t_work   i_q_data,
    output logic    o_q_pop,
    output logic    empty,
    input  logic    pop,
    output t_vertex o_vertex
);

    logic [1:0]        r_corner;
    logic [OCNT_W-1:0] r_out_cnt;
    logic              issue;
    logic              out_pop;
    logic              sx_neg, sy_neg;
    logic signed [48:0] rx_raw, ry_raw;

    logic [5:0]        r_v;
    logic signed [48:0] r_rxr, r_ryr;
    logic signed [32:0] r_rx, r_ry;
    logic [34:0]       r_ax, r_ay;
    logic              r_nx2, r_ny2, r_nx3, r_ny3, r_nx4, r_ny4;
    logic [50:0]       r_hx, r_lx, r_hy, r_ly;
    logic [37:0]       r_mx, r_my;
    t_work             r_w0, r_w1;
    logic [1:0]        r_k0, r_k1, r_k2, r_k3, r_k4;
    logic              r_d2, r_d3, r_d4;
    logic [1:0]        r_s2, r_s3, r_s4;
    t_vertex           r_out5;

    logic signed [48:0] tx, ty;
    logic signed [34:0] dx, dy;
    logic [67:0]       sum_x, sum_y;
    t_vertex           vtx;

    t_vertex           r_fifo [ODEPTH];
    logic [OPTR_W-1:0] r_wr, r_rd;
    logic [OCNT_W-1:0] r_fcnt;

    assign out_pop = pop && !empty;
    assign issue   = !i_q_empty && (r_out_cnt < OCNT_W'(ODEPTH));
    assign o_q_pop = issue && (r_corner == CORNER_BL);

    // credits cover every vertex in flight plus those in the output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner  <= CORNER_TL;
            r_out_cnt <= '0;
            r_v       <= '0;
        end else begin
            if (issue) begin
                r_corner <= r_corner + 2'd1;
            end
            r_out_cnt <= r_out_cnt + OCNT_W'(issue) - OCNT_W'(out_pop);
            r_v       <= {r_v[4:0], issue};
        end
    end

    always_comb begin
        sx_neg = (r_corner == CORNER_TL) || (r_corner == CORNER_BL);
        sy_neg = (r_corner == CORNER_BR) || (r_corner == CORNER_BL);
        rx_raw = (sx_neg ? -49'(i_q_data.cw) : 49'(i_q_data.cw))
               + (sy_neg ? -49'(i_q_data.sh) : 49'(i_q_data.sh));
        ry_raw = (sy_neg ? -49'(i_q_data.ch) : 49'(i_q_data.ch))
               - (sx_neg ? -49'(i_q_data.sw) : 49'(i_q_data.sw));
        // round half away from zero: negatives add one less
        tx = r_rxr + 49'sd32768 - $signed({48'd0, r_rxr[48]});
        ty = r_ryr + 49'sd32768 - $signed({48'd0, r_ryr[48]});
        dx = 35'(r_w1.cx) + 35'(r_rx) - 35'(i_cfg.camera_x);
        dy = 35'(r_w1.cy) + 35'(r_ry) - 35'(i_cfg.camera_y);
        sum_x = {1'b0, r_hx, 16'd0} + 68'(r_lx) + 68'd536870912;
        sum_y = {1'b0, r_hy, 16'd0} + 68'(r_ly) + 68'd536870912;
    end

    always_ff @(posedge i_clk) begin
        r_w0  <= i_q_data;
        r_k0  <= r_corner;
        r_rxr <= rx_raw;
        r_ryr <= ry_raw;
        r_w1  <= r_w0;
        r_k1  <= r_k0;
        r_rx  <= tx[48:16];
        r_ry  <= ty[48:16];
        r_k2  <= r_k1;
        r_d2  <= r_w1.depth;
        r_s2  <= r_w1.slot;
        r_nx2 <= dx[34];
        r_ny2 <= dy[34];
        r_ax  <= dx[34] ? 35'(-dx) : 35'(dx);
        r_ay  <= dy[34] ? 35'(-dy) : 35'(dy);
        r_k3  <= r_k2;
        r_d3  <= r_d2;
        r_s3  <= r_s2;
        r_nx3 <= r_nx2;
        r_ny3 <= r_ny2;
        r_hx  <= 51'(r_ax) * 51'(i_cfg.x_scale[31:16]);
        r_lx  <= 51'(r_ax) * 51'(i_cfg.x_scale[15:0]);
        r_hy  <= 51'(r_ay) * 51'(i_cfg.y_scale[31:16]);
        r_ly  <= 51'(r_ay) * 51'(i_cfg.y_scale[15:0]);
        r_k4  <= r_k3;
        r_d4  <= r_d3;
        r_s4  <= r_s3;
        r_nx4 <= r_nx3;
        r_ny4 <= r_ny3;
        r_mx  <= sum_x[67:30];
        r_my  <= sum_y[67:30];
        r_out5 <= vtx;
    end

    // saturate to the signed 32-bit range
    always_comb begin
        if (r_nx4) begin
            vtx.vertex_x = (r_mx >= 38'h80000000) ? 32'sh80000000 : -$signed(r_mx[31:0]);
        end else begin
            vtx.vertex_x = (r_mx > 38'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(r_mx[31:0]);
        end
        if (r_ny4) begin
            vtx.vertex_y = (r_my >= 38'h80000000) ? 32'sh80000000 : -$signed(r_my[31:0]);
        end else begin
            vtx.vertex_y = (r_my > 38'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(r_my[31:0]);
        end
        vtx.depth        = r_d4;
        vtx.texture_slot = r_s4;
        vtx.corner       = r_k4;
        vtx.last_vertex  = (r_k4 == CORNER_BL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fcnt <= '0;
        end else begin
            if (r_v[5]) begin
                r_wr <= r_wr + 1'b1;
            end
            if (out_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fcnt <= r_fcnt + OCNT_W'(r_v[5]) - OCNT_W'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[5]) begin
            r_fifo[r_wr] <= r_out5;
        end
    end

    assign empty    = (r_fcnt == '0);
    assign o_vertex = r_fifo[r_rd];

endmodule

>>> rtl/sprite_quad_vertex_transform.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex transform
// Turns one sprite into the four device-space vertices of its quad.
// ----------------------------------------------------------------------------
// Usage:
//   Sprite input is a queue: drive i_sprite and push while full is low.
//   Each sprite yields four vertices, top-left, top-right, bottom-right,
//   bottom-left; the oldest one sits on o_vertex while empty is low and
//   leaves on pop. last_vertex marks the fourth vertex of each quad.
//   Registers (camera_x, camera_y, x_scale, y_scale) are written through
//   cfg_valid/cfg_ready with i_cfg_index and i_cfg_data; cfg_ready is
//   always high. Write them only while no sprite is in flight.
//   Path: an accepted sprite passes 7 front stages, the work queue, 6 back
//   stages and the output buffer before its first vertex can be popped.
//   Throughput: one vertex per cycle from the back end while a sprite waits
//   in the work queue and the output buffer has room; the front accepts a
//   sprite per cycle until 8 are held in its stages and the work queue.
//   Reset empties both queues and loads the register defaults.
//   A stalled receiver fills the 8-entry output buffer, the back stops
//   issuing, and once 8 sprites wait in the front and the work queue, full
//   rises.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_transform
    import sqvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_sprite     i_sprite,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output t_vertex     o_vertex,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_push, q_pop, q_empty, q_full;
    t_work q_in, q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.camera_x <= '0;
            r_cfg.camera_y <= '0;
            r_cfg.x_scale  <= X_SCALE_RST;
            r_cfg.y_scale  <= Y_SCALE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (i_cfg_index)
                REG_CAMERA_X: r_cfg.camera_x <= i_cfg_data;
                REG_CAMERA_Y: r_cfg.camera_y <= i_cfg_data;
                REG_X_SCALE:  r_cfg.x_scale  <= i_cfg_data;
                REG_Y_SCALE:  r_cfg.y_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sqvt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sprite (i_sprite),
        .o_full   (full),
        .i_q_pop  (q_pop),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    sqvt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sqvt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_vertex  (o_vertex)
    );

`ifndef NO_ASSERTIONS
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full && !q_pop))
        else $error("work queue pushed while full");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("work queue popped while empty");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_last_on_bl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_vertex.last_vertex == (o_vertex.corner == CORNER_BL)))
        else $error("last vertex flag out of step with corner");
`endif

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex transform testbench
// Pushes sprites through the quad transform under several camera and scale
// settings and checks every vertex against a bit-accurate predictor.
// Random gaps on both sides and one long receiver hold-off included.
// ----------------------------------------------------------------------------
module tb_top;
    import sqvt_pkg::*;

    typedef struct {
        t_sprite            spr;
        bit                 known;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    t_sprite     i_sprite;
    logic        full;
    logic        empty;
    logic        pop;
    t_vertex     o_vertex;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic [31:0]        scl_x;
    logic [31:0]        scl_y;

    t_vertex vertex_q[$];
    t_row    dir_rows[$];
    int      errors;
    int      n_sprites;
    int      n_vertices;
    bit      hold_req;
    int      hold_left;

    sprite_quad_vertex_transform u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_sprite    (i_sprite),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_vertex    (o_vertex),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Q1.15 sine of a Q0.32 phase, quarter wave mirrored
    function automatic longint sine_q15(logic [31:0] ph);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned acc;
        longint unsigned q;
        z = ph[29:0];
        if (ph[30]) begin
            z = 64'd1073741824 - z;
        end
        z2  = (z * z) >> 30;
        acc = 64'd5026994 - ((64'd172272 * z2) >> 30);
        acc = 64'd85569306 - ((acc * z2) >> 30);
        acc = 64'd693598668 - ((acc * z2) >> 30);
        acc = 64'd1686629713 - ((acc * z2) >> 30);
        acc = (acc * z) >> 30;
        q = (acc + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return ph[31] ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint round16(longint v);
        if (v < 0) begin
            return -((-v + 32768) >>> 16);
        end
        return (v + 32768) >>> 16;
    endfunction

    function automatic logic [31:0] to_device(longint d, logic [31:0] scale);
        bit          neg;
        logic [95:0] mag;
        neg = d < 0;
        mag = 96'(neg ? -d : d) * 96'(scale);
        mag = (mag + (96'd1 << 29)) >> 30;
        if (neg) begin
            if (mag >= 96'h8000_0000) begin
                return 32'h8000_0000;
            end
            return -mag[31:0];
        end
        if (mag > 96'h7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    // expand one sprite into its four expected vertices
    function automatic void queue_quad(t_row row);
        longint          rot_u;
        longint          k;
        logic [31:0]     ph;
        longint          sn;
        longint          cs;
        longint          ox;
        longint          oy;
        longint          rx;
        longint          ry;
        t_vertex         v;
        rot_u = longint'(row.spr.rotation_deg) + DEG_TURN;
        k  = ((rot_u * SINE_DEPTH + DEG_TURN / 2) / DEG_TURN) % SINE_DEPTH;
        ph = 32'((longint'(k) << 32) / SINE_DEPTH);
        sn = sine_q15(ph);
        cs = sine_q15(ph + 32'h4000_0000);
        for (int c = 0; c < 4; c++) begin
            ox = (c == 0 || c == 3) ? -longint'(row.spr.width) : longint'(row.spr.width);
            oy = (c < 2) ? longint'(row.spr.height) : -longint'(row.spr.height);
            rx = round16(cs * ox + sn * oy);
            ry = round16(cs * oy - sn * ox);
            v.vertex_x     = to_device(longint'(row.spr.centre_x) + rx - longint'(cam_x), scl_x);
            v.vertex_y     = to_device(longint'(row.spr.centre_y) + ry - longint'(cam_y), scl_y);
            v.depth        = (row.spr.layer == LAYER_FLOOR);
            v.texture_slot = (row.spr.draw_kind == KIND_TEXT || row.spr.draw_kind == KIND_CIRCLE)
                             ? row.spr.draw_kind : KIND_RECT;
            v.corner       = 2'(c);
            v.last_vertex  = (v.corner == CORNER_BL);
            if (row.known) begin
                v.vertex_x = row.vx;
                v.vertex_y = row.vy;
            end
            vertex_q.push_back(v);
        end
    endfunction

    task automatic add_row(input logic [31:0] cx, input logic [31:0] cy,
                           input logic [30:0] w, input logic [30:0] h,
                           input logic [15:0] rot, input logic [1:0] kind,
                           input logic lay, input bit known,
                           input logic [31:0] vx, input logic [31:0] vy);
        t_row row;
        row.spr.centre_x     = cx;
        row.spr.centre_y     = cy;
        row.spr.width        = w;
        row.spr.height       = h;
        row.spr.rotation_deg = rot;
        row.spr.draw_kind    = kind;
        row.spr.layer        = lay;
        row.known            = known;
        row.vx               = vx;
        row.vy               = vy;
        dir_rows.push_back(row);
    endtask

    function automatic t_sprite rand_sprite();
        t_sprite s;
        s.centre_x = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 'h3FFFFF)) - 'h200000;
        s.centre_y = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 'h3FFFFF)) - 'h200000;
        s.width    = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 'hFFFFF));
        s.height   = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 'hFFFFF));
        s.rotation_deg = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                         : 16'($urandom_range(0, 2 * DEG_HALF) - DEG_HALF);
        s.draw_kind = 2'($urandom);
        s.layer     = 1'($urandom);
        return s;
    endfunction

    task automatic send_sprite(input t_row row);
        int gap;
        @(negedge i_clk);
        push     <= 1'b1;
        i_sprite <= row.spr;
        do begin
            @(posedge i_clk);
        end while (full);
        queue_quad(row);
        n_sprites++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        push        <= 1'b0;
        cfg_valid   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!cfg_ready);
        case (idx)
            REG_CAMERA_X: cam_x = data;
            REG_CAMERA_Y: cam_y = data;
            REG_X_SCALE:  scl_x = data;
            REG_Y_SCALE:  scl_y = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        wait (vertex_q.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        t_row row;
        row.known = 1'b0;
        row.vx    = '0;
        row.vy    = '0;
        for (int n = 0; n < count; n++) begin
            row.spr = rand_sprite();
            send_sprite(row);
        end
    endtask

    // receiver: random pops, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            pop <= 1'b0;
            hold_left <= 400;
            hold_req <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 50);
        end
    end

    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && pop && !empty) begin
            n_vertices++;
            if (vertex_q.size() == 0) begin
                $error("unexpected vertex x=%0d y=%0d", o_vertex.vertex_x, o_vertex.vertex_y);
                errors++;
            end else begin
                e = vertex_q.pop_front();
                if (o_vertex.vertex_x !== e.vertex_x) begin
                    $error("vertex_x expected %0d got %0d", e.vertex_x, o_vertex.vertex_x);
                    errors++;
                end
                if (o_vertex.vertex_y !== e.vertex_y) begin
                    $error("vertex_y expected %0d got %0d", e.vertex_y, o_vertex.vertex_y);
                    errors++;
                end
                if (o_vertex.depth !== e.depth) begin
                    $error("depth expected %0d got %0d", e.depth, o_vertex.depth);
                    errors++;
                end
                if (o_vertex.texture_slot !== e.texture_slot) begin
                    $error("texture_slot expected %0d got %0d", e.texture_slot,
                           o_vertex.texture_slot);
                    errors++;
                end
                if (o_vertex.corner !== e.corner) begin
                    $error("corner expected %0d got %0d", e.corner, o_vertex.corner);
                    errors++;
                end
                if (o_vertex.last_vertex !== e.last_vertex) begin
                    $error("last_vertex expected %0d got %0d", e.last_vertex,
                           o_vertex.last_vertex);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors      = 0;
        n_sprites   = 0;
        n_vertices  = 0;
        hold_req    = 1'b0;
        hold_left   = 0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_sprite    = '0;
        cfg_valid   = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cam_x       = '0;
        cam_y       = '0;
        scl_x       = X_SCALE_RST;
        scl_y       = Y_SCALE_RST;

        // zero-size sprites at the origin land on the origin with the camera at zero
        add_row(0, 0, 0, 0, 0, KIND_RECT, 1'b0, 1'b1, 0, 0);
        add_row(0, 0, 0, 0, 16'd11520, KIND_CIRCLE, 1'b1, 1'b1, 0, 0);
        add_row(0, 0, 0, 0, -16'sd23040, KIND_TEXT, 1'b0, 1'b1, 0, 0);
        add_row(0, 0, 0, 0, 16'd23040, 2'd3, 1'b1, 1'b1, 0, 0);
        add_row(32'h0001_0000, 32'h0002_0000, 31'h0001_0000, 31'h0001_0000, 0,
                KIND_RECT, 1'b0, 1'b0, 0, 0);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0,
                KIND_TEXT, 1'b1, 1'b0, 0, 0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd11520,
                KIND_CIRCLE, 1'b0, 1'b0, 0, 0);
        add_row(0, 0, 31'h0010_0000, 31'h0004_0000, 16'd5760, KIND_RECT, 1'b1, 1'b0, 0, 0);
        add_row(0, 0, 31'h0010_0000, 31'h0004_0000, 16'h8000, 2'd3, 1'b0, 1'b0, 0, 0);
        add_row(0, 0, 31'h0010_0000, 31'h0004_0000, 16'h7FFF, KIND_TEXT, 1'b1, 1'b0, 0, 0);
        add_row(0, 0, 31'h0010_0000, 31'h0004_0000, -16'sd23040, KIND_CIRCLE, 1'b0, 1'b0, 0, 0);
        add_row(0, 0, 31'h0010_0000, 31'h0004_0000, 16'd23040, KIND_RECT, 1'b1, 1'b0, 0, 0);
        add_row(32'hFFFF_FFFF, 32'h0000_0001, 1, 1, 16'd1, KIND_TEXT, 1'b0, 1'b0, 0, 0);
        add_row(0, 0, 31'h0001_0000, 31'h0020_0000, -16'sd64, KIND_RECT, 1'b1, 1'b0, 0, 0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            send_sprite(dir_rows[r]);
        end
        run_random(25);
        drain();

        // extremes: far camera, full-scale gain, saturating outputs
        write_reg(REG_CAMERA_X, 32'h7FFF_FFFF);
        write_reg(REG_CAMERA_Y, 32'h8000_0000);
        write_reg(REG_X_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_Y_SCALE, 32'hFFFF_FFFF);
        write_reg(8'd7, 32'hDEAD_BEEF);
        send_sprite(dir_rows[5]);
        send_sprite(dir_rows[6]);
        run_random(15);
        drain();

        write_reg(REG_CAMERA_X, 32'h8000_0000);
        write_reg(REG_CAMERA_Y, 32'h7FFF_FFFF);
        write_reg(REG_X_SCALE, 32'h0000_0000);
        write_reg(REG_Y_SCALE, 32'h4000_0000);
        run_random(15);
        drain();

        // random setting with one long receiver hold-off
        write_reg(REG_CAMERA_X, $signed($urandom_range(0, 'h3FFFFF)) - 'h200000);
        write_reg(REG_CAMERA_Y, $urandom);
        write_reg(REG_X_SCALE, $urandom_range(0, 'h8000_0000));
        write_reg(REG_Y_SCALE, $urandom);
        hold_req = 1'b1;
        run_random(40);
        drain();

        write_reg(REG_CAMERA_X, 0);
        write_reg(REG_CAMERA_Y, 0);
        write_reg(REG_X_SCALE, X_SCALE_RST);
        write_reg(REG_Y_SCALE, Y_SCALE_RST);
        run_random(25);
        drain();

        $display("covered %0d sprites, %0d vertices over 5 register settings",
                 n_sprites, n_vertices);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
